>>> rtl/wsc_pkg.sv
// Shared types and constants for the wavetable sound channel core.
// Depends on nothing; every other RTL file refers to it by scoped names.
`default_nettype none

package wsc_pkg;

    // Channel organization.
    localparam int NUM_CHANNELS = 8;
    localparam int CHAN_W       = 3;
    localparam int COUNT_W      = 4;

    // Field widths.
    localparam int ADDR_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int NIB_W        = 4;
    localparam int INDEX_W      = 7;
    localparam int FREQ_W       = 18;
    localparam int PHASE_W      = 32;
    localparam int PHASE_FRAC_W = 18;
    localparam int LEN_W        = 6;
    localparam int SAMPLE_W     = 14;
    localparam int WAVE_FULL_W  = 16;
    localparam int VOL_SHIFT    = 6;

    // Accumulator reload step is the step count times the active count, shifted by this amount.
    localparam int ACC_STEP_SHIFT = 20;
    localparam int STEP_N_W       = PHASE_W - ACC_STEP_SHIFT;

    // Shared divider sizing.
    localparam int DIV_NUM_W = 14;
    localparam int DIV_DEN_W = 6;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Bus decode.
    localparam logic [ADDR_W-1:0] DATA_PORT  = 16'h4800;
    localparam logic [ADDR_W-1:0] INDEX_PORT = 16'hF800;

    // Byte offsets of the channel registers within a channel's eight bytes.
    localparam logic [2:0] CREG_FREQ_LO  = 3'd0;
    localparam logic [2:0] CREG_FREQ_MID = 3'd2;
    localparam logic [2:0] CREG_FREQ_HI  = 3'd4;
    localparam logic [2:0] CREG_OFFSET   = 3'd6;
    localparam logic [2:0] CREG_VOLUME   = 3'd7;

    // Wave length encoding, in units of 2^PHASE_FRAC_W.
    localparam logic [BYTE_W-1:0]  LEN_SEL_MASK = 8'h1C;
    localparam logic [LEN_W-1:0]   LEN_BASE     = 6'h20;
    localparam logic [LEN_W-1:0]   LEN_RESET    = 6'h10;
    localparam logic [COUNT_W-1:0] ACTIVE_RESET = 4'd8;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_RENDER = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Request and response of the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/wsc_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on wsc_pkg for widths and the request/response structs.
`default_nettype none

module wsc_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire wsc_pkg::div_req_t req,
    output wsc_pkg::div_rsp_t   rsp
);

    logic                              run_reg;
    logic                              done_reg;
    logic [wsc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [wsc_pkg::DIV_NUM_W-1:0]     quo_reg;
    logic [wsc_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [wsc_pkg::DIV_DEN_W-1:0]     den_reg;

    logic [wsc_pkg::DIV_DEN_W:0]       shifted;
    logic [wsc_pkg::DIV_DEN_W:0]       diff;
    logic                              fits;

    // One trial subtraction of the divisor from the partial remainder.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[wsc_pkg::DIV_NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = ~diff[wsc_pkg::DIV_DEN_W];
    end

    // Iteration counter, remainder and quotient shift register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= wsc_pkg::DIV_CNT_W'(wsc_pkg::DIV_NUM_W);
                quo_reg <= req.num;
                rem_reg <= '0;
                den_reg <= req.den;
            end
            else if (run_reg)
            begin
                rem_reg <= fits ? diff[wsc_pkg::DIV_DEN_W-1:0]
                                : shifted[wsc_pkg::DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[wsc_pkg::DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wsc_pkg::DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/wavetable_sound_channels_core.sv
// Eight-channel 4-bit wavetable sound core: bus port, wave RAM, channel state.
// Bus beats, kind 3 and inactive channels end in S_DISPATCH; a render without
// accumulator underflow ends in S_CHECK, or after the wave lookup if the volume is
// dirty; with underflow two shared divider passes precede the lookup. One beat at
// a time; a new start is taken in the cycle done shows.
// Reset is asynchronous and active low; results cannot be stalled by the receiver.
// Depends on wsc_pkg and wsc_divider.
`default_nettype none

module wavetable_sound_channels_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    kind,
    input  wire logic [wsc_pkg::ADDR_W-1:0]    bus_address,
    input  wire logic [wsc_pkg::BYTE_W-1:0]    bus_data,
    input  wire logic [wsc_pkg::CHAN_W-1:0]    channel,
    input  wire logic                          cfg_write,
    input  wire logic [wsc_pkg::PHASE_W-1:0]   cfg_data,
    output logic                               done,
    output logic [wsc_pkg::BYTE_W-1:0]         read_data,
    output logic [wsc_pkg::SAMPLE_W-1:0]       sample
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHECK,
        S_QUOT,
        S_DIV_N,
        S_MUL,
        S_ADD,
        S_DIV_M,
        S_WAVE_ADDR,
        S_WAVE_DATA
    } state_t;

    localparam int WAVE_DEPTH = 1 << wsc_pkg::INDEX_W;

    state_t                                state_reg;
    logic [1:0]                            kind_reg;
    logic [wsc_pkg::ADDR_W-1:0]            addr_reg;
    logic [wsc_pkg::BYTE_W-1:0]            data_reg;
    logic [wsc_pkg::CHAN_W-1:0]            ch_reg;
    logic [wsc_pkg::PHASE_W-1:0]           cycle_rate_reg;
    logic [wsc_pkg::INDEX_W-1:0]           ram_index_reg;
    logic                                  auto_inc_reg;
    logic [wsc_pkg::COUNT_W-1:0]           active_reg;

    // Per-channel state.
    logic [wsc_pkg::FREQ_W-1:0]    freq_reg   [wsc_pkg::NUM_CHANNELS];
    logic [wsc_pkg::PHASE_W-1:0]   phase_reg  [wsc_pkg::NUM_CHANNELS];
    logic [wsc_pkg::PHASE_W-1:0]   pacc_reg   [wsc_pkg::NUM_CHANNELS];
    logic [wsc_pkg::LEN_W-1:0]     len_reg    [wsc_pkg::NUM_CHANNELS];
    logic [wsc_pkg::BYTE_W-1:0]    offset_reg [wsc_pkg::NUM_CHANNELS];
    logic [wsc_pkg::NIB_W-1:0]     vol_reg    [wsc_pkg::NUM_CHANNELS];
    logic                          dirty_reg  [wsc_pkg::NUM_CHANNELS];
    logic [wsc_pkg::SAMPLE_W-1:0]  out_reg    [wsc_pkg::NUM_CHANNELS];

    // Render working registers.
    logic [wsc_pkg::PHASE_W-1:0]           acc_reg;
    logic [wsc_pkg::PHASE_W-1:0]           mag_reg;
    logic [wsc_pkg::STEP_N_W-1:0]          n_reg;
    logic [wsc_pkg::STEP_N_W-1:0]          step_prod_reg;
    logic [wsc_pkg::FREQ_W+wsc_pkg::STEP_N_W-1:0] phase_prod_reg;
    logic [wsc_pkg::PHASE_FRAC_W-1:0]      phase_tmp_reg;
    logic [wsc_pkg::BYTE_W-1:0]            wave_byte_reg;
    logic                                  pos_lsb_reg;

    // Result registers.
    logic                                  done_reg;
    logic [wsc_pkg::BYTE_W-1:0]            read_data_reg;
    logic [wsc_pkg::SAMPLE_W-1:0]          sample_reg;

    // Wave RAM: one byte holds two nibbles, low nibble at the even position.
    logic [wsc_pkg::BYTE_W-1:0]            wave_mem [WAVE_DEPTH];

    wsc_pkg::div_req_t                     div_req;
    wsc_pkg::div_rsp_t                     div_rsp;

    wsc_pkg::kind_t                        kind_e;
    logic                                  active_ok;
    logic                                  chan_reg_hit;
    logic [wsc_pkg::LEN_W-1:0]             new_len;
    logic [wsc_pkg::PHASE_W-1:0]           cur_acc;
    logic [wsc_pkg::STEP_N_W-1:0]          mag_q;
    logic [wsc_pkg::DIV_NUM_W-1:0]         quot_num;
    logic [wsc_pkg::PHASE_W-1:0]           phase_sum;
    logic [wsc_pkg::PHASE_W-1:0]           acc_sum;
    logic [wsc_pkg::BYTE_W-1:0]            wave_pos;
    logic [wsc_pkg::NIB_W-1:0]             wave_nib;
    logic [2*wsc_pkg::NIB_W-1:0]           wave_prod;
    logic [wsc_pkg::WAVE_FULL_W-1:0]       wave_full;
    logic                                  mem_we;
    logic                                  index_step;

    // Decode of the captured beat.
    always_comb
    begin
        kind_e       = wsc_pkg::kind_t'(kind_reg);
        active_ok    = ({1'b0, ch_reg} + active_reg)
                       >= wsc_pkg::COUNT_W'(wsc_pkg::NUM_CHANNELS);
        chan_reg_hit = ram_index_reg[wsc_pkg::INDEX_W-1];
        new_len      = wsc_pkg::LEN_BASE
                       - wsc_pkg::LEN_W'(data_reg & wsc_pkg::LEN_SEL_MASK);
        mem_we       = (state_reg == S_DISPATCH) && (kind_e == wsc_pkg::KIND_WRITE)
                       && (addr_reg == wsc_pkg::DATA_PORT);
        index_step   = (state_reg == S_DISPATCH) && auto_inc_reg
                       && (addr_reg == wsc_pkg::DATA_PORT)
                       && ((kind_e == wsc_pkg::KIND_WRITE) || (kind_e == wsc_pkg::KIND_READ));
    end

    // Accumulator and phase arithmetic.
    always_comb
    begin
        cur_acc   = pacc_reg[ch_reg] - cycle_rate_reg;
        mag_q     = mag_reg[wsc_pkg::PHASE_W-1:wsc_pkg::ACC_STEP_SHIFT]
                    + wsc_pkg::STEP_N_W'(|mag_reg[wsc_pkg::ACC_STEP_SHIFT-1:0]);
        quot_num  = wsc_pkg::DIV_NUM_W'(mag_q) + wsc_pkg::DIV_NUM_W'(active_reg)
                    - wsc_pkg::DIV_NUM_W'(1);
        phase_sum = phase_reg[ch_reg] + wsc_pkg::PHASE_W'(phase_prod_reg);
        acc_sum   = acc_reg + {step_prod_reg, {wsc_pkg::ACC_STEP_SHIFT{1'b0}}};
    end

    // Wave lookup and volume scaling.
    always_comb
    begin
        wave_pos  = phase_reg[ch_reg][wsc_pkg::PHASE_FRAC_W +: wsc_pkg::BYTE_W]
                    + offset_reg[ch_reg];
        wave_nib  = pos_lsb_reg ? wave_byte_reg[wsc_pkg::BYTE_W-1:wsc_pkg::NIB_W]
                                : wave_byte_reg[wsc_pkg::NIB_W-1:0];
        wave_prod = {{wsc_pkg::NIB_W{1'b0}}, wave_nib}
                    * {{wsc_pkg::NIB_W{1'b0}}, vol_reg[ch_reg]};
        wave_full = wsc_pkg::WAVE_FULL_W'(wave_prod) << wsc_pkg::VOL_SHIFT;
    end

    // Divider requests: step count first, then the phase wrap.
    always_comb
    begin
        div_req.start = (state_reg == S_QUOT) || (state_reg == S_ADD);
        if (state_reg == S_QUOT)
        begin
            div_req.num = quot_num;
            div_req.den = wsc_pkg::DIV_DEN_W'(active_reg);
        end
        else
        begin
            div_req.num = phase_sum[wsc_pkg::PHASE_W-1 -: wsc_pkg::DIV_NUM_W];
            div_req.den = len_reg[ch_reg];
        end
    end

    wsc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Wave RAM write on data port beats, registered read for rendering.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[ram_index_reg] <= data_reg;
        end
        if (state_reg == S_WAVE_ADDR)
        begin
            wave_byte_reg <= wave_mem[wave_pos[wsc_pkg::BYTE_W-1:1]];
            pos_lsb_reg   <= wave_pos[0];
        end
    end

    // Sequencer, channel state and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            addr_reg       <= '0;
            data_reg       <= '0;
            ch_reg         <= '0;
            cycle_rate_reg <= '0;
            ram_index_reg  <= '0;
            auto_inc_reg   <= 1'b1;
            active_reg     <= wsc_pkg::ACTIVE_RESET;
            for (int i = 0; i < wsc_pkg::NUM_CHANNELS; i++)
            begin
                freq_reg[i]   <= '0;
                phase_reg[i]  <= '0;
                pacc_reg[i]   <= '0;
                len_reg[i]    <= wsc_pkg::LEN_RESET;
                offset_reg[i] <= '0;
                vol_reg[i]    <= '0;
                dirty_reg[i]  <= 1'b0;
                out_reg[i]    <= '0;
            end
            acc_reg        <= '0;
            mag_reg        <= '0;
            n_reg          <= '0;
            step_prod_reg  <= '0;
            phase_prod_reg <= '0;
            phase_tmp_reg  <= '0;
            done_reg       <= 1'b0;
            read_data_reg  <= '0;
            sample_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_write)
            begin
                cycle_rate_reg <= cfg_data;
            end

            if (index_step)
            begin
                ram_index_reg <= ram_index_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg  <= kind;
                        addr_reg  <= bus_address;
                        data_reg  <= bus_data;
                        // Bus writes address the channel that ram_index points at.
                        ch_reg    <= (kind == wsc_pkg::KIND_WRITE)
                                     ? ram_index_reg[wsc_pkg::INDEX_W-2 -: wsc_pkg::CHAN_W]
                                     : channel;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    read_data_reg <= '0;
                    sample_reg    <= '0;
                    state_reg     <= S_IDLE;
                    done_reg      <= 1'b1;
                    case (kind_e)
                        wsc_pkg::KIND_WRITE:
                        begin
                            if (addr_reg == wsc_pkg::DATA_PORT && chan_reg_hit)
                            begin
                                // Channel register side effects of a data port write.
                                unique case (ram_index_reg[2:0])
                                    wsc_pkg::CREG_FREQ_LO:
                                        freq_reg[ch_reg][7:0] <= data_reg;
                                    wsc_pkg::CREG_FREQ_MID:
                                        freq_reg[ch_reg][15:8] <= data_reg;
                                    wsc_pkg::CREG_FREQ_HI:
                                    begin
                                        freq_reg[ch_reg][wsc_pkg::FREQ_W-1:16] <= data_reg[1:0];
                                        if (len_reg[ch_reg] != new_len)
                                        begin
                                            len_reg[ch_reg]   <= new_len;
                                            phase_reg[ch_reg] <= '0;
                                        end
                                    end
                                    wsc_pkg::CREG_OFFSET:
                                        offset_reg[ch_reg] <= data_reg;
                                    wsc_pkg::CREG_VOLUME:
                                    begin
                                        vol_reg[ch_reg]   <= data_reg[wsc_pkg::NIB_W-1:0];
                                        dirty_reg[ch_reg] <= 1'b1;
                                        if (ch_reg == wsc_pkg::CHAN_W'(wsc_pkg::NUM_CHANNELS - 1))
                                        begin
                                            active_reg <= wsc_pkg::COUNT_W'(data_reg[6:4])
                                                          + wsc_pkg::COUNT_W'(1);
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            else if (addr_reg == wsc_pkg::INDEX_PORT)
                            begin
                                ram_index_reg <= data_reg[wsc_pkg::INDEX_W-1:0];
                                auto_inc_reg  <= data_reg[wsc_pkg::BYTE_W-1];
                            end
                        end
                        wsc_pkg::KIND_READ:
                        begin
                            read_data_reg <= addr_reg[wsc_pkg::ADDR_W-1 -: wsc_pkg::BYTE_W];
                        end
                        wsc_pkg::KIND_RENDER:
                        begin
                            if (active_ok)
                            begin
                                acc_reg   <= cur_acc;
                                done_reg  <= 1'b0;
                                state_reg <= S_CHECK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                S_CHECK:
                begin
                    if (!acc_reg[wsc_pkg::PHASE_W-1])
                    begin
                        pacc_reg[ch_reg] <= acc_reg;
                        if (dirty_reg[ch_reg])
                        begin
                            // Only this volume refresh consumes the dirty mark.
                            dirty_reg[ch_reg] <= 1'b0;
                            state_reg         <= S_WAVE_ADDR;
                        end
                        else
                        begin
                            sample_reg <= out_reg[ch_reg];
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        mag_reg   <= '0 - acc_reg;
                        state_reg <= S_QUOT;
                    end
                end

                S_QUOT:
                begin
                    state_reg <= S_DIV_N;
                end

                S_DIV_N:
                begin
                    if (div_rsp.done)
                    begin
                        n_reg     <= div_rsp.quo[wsc_pkg::STEP_N_W-1:0];
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    step_prod_reg  <= wsc_pkg::STEP_N_W'(n_reg * active_reg);
                    phase_prod_reg <= n_reg * freq_reg[ch_reg];
                    state_reg      <= S_ADD;
                end

                S_ADD:
                begin
                    pacc_reg[ch_reg] <= acc_sum;
                    phase_tmp_reg    <= phase_sum[wsc_pkg::PHASE_FRAC_W-1:0];
                    state_reg        <= S_DIV_M;
                end

                S_DIV_M:
                begin
                    if (div_rsp.done)
                    begin
                        phase_reg[ch_reg] <= wsc_pkg::PHASE_W'({div_rsp.rem, phase_tmp_reg});
                        state_reg         <= S_WAVE_ADDR;
                    end
                end

                S_WAVE_ADDR:
                begin
                    state_reg <= S_WAVE_DATA;
                end

                S_WAVE_DATA:
                begin
                    out_reg[ch_reg]   <= wave_full[wsc_pkg::SAMPLE_W-1:0];
                    sample_reg        <= wave_full[wsc_pkg::SAMPLE_W-1:0];
                    done_reg          <= 1'b1;
                    state_reg         <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

>>> rtl/wsc_checker.sv
// Port-level checks of the wavetable sound channel core, bound to the top level.
// Depends on wsc_pkg for widths and on wavetable_sound_channels_core for the bind.
`default_nettype none

module wsc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          done,
    input  wire logic [wsc_pkg::BYTE_W-1:0]    read_data,
    input  wire logic [wsc_pkg::SAMPLE_W-1:0]  sample
);

    // An accepted beat makes the core busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after an accepted beat");

    // A result beat is shown only when the core has gone back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while core still busy");

    // No result can follow an idle cycle directly.
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !done)
        else $error("result beat without a beat in flight");

    // A bus read and a render never both carry data in one result beat.
    a_one_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (sample != '0)) |-> (read_data == '0))
        else $error("read data and sample both nonzero");

endmodule

bind wavetable_sound_channels_core wsc_checker u_wsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .read_data (read_data),
    .sample    (sample)
);

`default_nettype wire
